/* rtl/core/lsq_pkg.sv */
// Shared types and constants for the largest ones square finder.
package lsq_pkg;

  localparam int SIZE_W = 11;
  localparam int COLS_W = 11;

  localparam logic [COLS_W-1:0] COLUMNS_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic pixel;
    logic last;
    logic first_row;
    logic first_col;
  } lsq_flags_t;

endpackage

/* rtl/core/lsq_front.sv */
// Input side: takes pixel items, tracks the raster position and queues classified items.
module lsq_front import lsq_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int CW = $clog2(MAX_COLS),
  parameter int RW = $clog2(MAX_ROWS),
  parameter int QW = $bits(lsq_flags_t) + CW + RW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [COLS_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              pixel,
  input  logic              frame_last,
  input  logic              q_full,
  input  logic              clearing,
  output logic              q_push,
  output logic [QW-1:0]     q_data
);

  localparam int XW = (COLS_W > CW + 1) ? COLS_W : CW + 1;

  logic [COLS_W-1:0] columns;
  logic [CW-1:0]     col_count;
  logic [RW-1:0]     row_count;
  logic [XW-1:0]     cols_x;
  logic [CW:0]       ncols;
  logic [CW-1:0]     last_col;
  logic [CW-1:0]     col;
  logic              row_end;
  lsq_flags_t        flags;

  always_comb begin
    cols_x = XW'(columns);
    if (columns == '0) begin
      ncols = (CW+1)'(1);
    end else if (cols_x > XW'(MAX_COLS)) begin
      ncols = (CW+1)'(MAX_COLS);
    end else begin
      ncols = cols_x[CW:0];
    end
    last_col = CW'(ncols - 1'b1);
    // A column count left past a shortened row is pinned to its last column.
    col = ({1'b0, col_count} >= ncols) ? last_col : col_count;
    row_end = (col == last_col);
    flags.pixel     = pixel;
    flags.last      = frame_last;
    flags.first_row = (row_count == '0);
    flags.first_col = (col == '0);
  end

  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;
  assign q_data   = {flags, col, row_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= COLUMNS_RESET;
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        columns <= cfg_wr_data;
      end
      if (q_push) begin
        if (frame_last) begin
          col_count <= '0;
          row_count <= '0;
        end else if (row_end) begin
          col_count <= '0;
          if (row_count != RW'(MAX_ROWS - 1)) begin
            row_count <= row_count + 1'b1;
          end
        end else begin
          col_count <= col + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/lsq_queue.sv */
// Two-entry queue between the front and back parts.
module lsq_queue import lsq_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]  slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lsq_back.sv */
// Work side: line buffer, square size recurrence, best tracking and result register.
module lsq_back import lsq_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int CW = $clog2(MAX_COLS),
  parameter int RW = $clog2(MAX_ROWS),
  parameter int QW = $bits(lsq_flags_t) + CW + RW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [QW-1:0]     q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIZE_W-1:0] square_size,
  output logic [SIZE_W-1:0] top_row,
  output logic [SIZE_W-1:0] left_column
);

  localparam int MW = (RW > CW) ? RW : CW;
  localparam int PW = ((MW > SIZE_W) ? MW : SIZE_W) + 1;

  logic [SIZE_W-1:0] mem [MAX_COLS];

  logic              clr_active;
  logic [CW-1:0]     clr_addr;

  lsq_flags_t        q_flags;
  logic [CW-1:0]     q_col;

  logic              a_valid;
  lsq_flags_t        a_flags;
  logic [CW-1:0]     a_col;
  logic [RW-1:0]     a_row;
  logic [SIZE_W-1:0] rd_data;
  logic              fwd;
  logic [SIZE_W-1:0] fwd_data;
  logic              a_fire;

  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diag_size;
  logic [SIZE_W-1:0] best_size;
  logic [RW-1:0]     best_row;
  logic [CW-1:0]     best_col;

  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] diag;
  logic [SIZE_W-1:0] left;
  logic [SIZE_W-1:0] min_ul;
  logic [SIZE_W-1:0] min3;
  logic [SIZE_W-1:0] size;
  logic [PW-1:0]     row_p1;
  logic [PW-1:0]     col_p1;
  logic [PW-1:0]     size_p;
  logic [SIZE_W-1:0] best_size_next;
  logic [RW-1:0]     best_row_next;
  logic [CW-1:0]     best_col_next;

  assign q_flags  = lsq_flags_t'(q_data[QW-1 -: $bits(lsq_flags_t)]);
  assign q_col    = q_data[RW +: CW];
  assign clearing = clr_active;

  assign a_fire = a_valid && (!a_flags.last || !out_valid || out_ready);
  assign q_pop  = !q_empty && !clr_active && (!a_valid || a_fire);

  always_comb begin
    // Nothing above the first row and nothing left of the first column.
    up   = a_flags.first_row ? '0 : (fwd ? fwd_data : rd_data);
    diag = (a_flags.first_row || a_flags.first_col) ? '0 : diag_size;
    left = a_flags.first_col ? '0 : left_size;
    min_ul = (left < up) ? left : up;
    min3   = (min_ul < diag) ? min_ul : diag;
    if (!a_flags.pixel) begin
      size = '0;
    end else if (min3 == SIZE_SAT) begin
      size = SIZE_SAT;
    end else begin
      size = min3 + 1'b1;
    end

    row_p1 = PW'(a_row) + 1'b1;
    col_p1 = PW'(a_col) + 1'b1;
    size_p = PW'(size);
    best_size_next = best_size;
    best_row_next  = best_row;
    best_col_next  = best_col;
    // Only a strictly larger square replaces the best, so the earliest one wins.
    if (size > best_size) begin
      best_size_next = size;
      best_row_next  = (size_p <= row_p1) ? RW'(row_p1 - size_p) : '0;
      best_col_next  = (size_p <= col_p1) ? CW'(col_p1 - size_p) : '0;
    end
  end

  // Line buffer: swept to zero after reset, then written once per pixel.
  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= '0;
    end else if (a_fire) begin
      mem[a_col] <= size;
    end
    if (q_pop) begin
      rd_data <= mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_flags  <= q_flags;
      a_col    <= q_col;
      a_row    <= q_data[RW-1:0];
      // The read sees the old entry when the same column is written at this edge.
      fwd      <= a_fire && (q_col == a_col);
      fwd_data <= size;
    end
    if (a_fire) begin
      left_size <= size;
      diag_size <= up;
    end
    if (a_fire && a_flags.last) begin
      square_size <= best_size_next;
      top_row     <= SIZE_W'(PW'(best_row_next) + 1'b1);
      left_column <= SIZE_W'(PW'(best_col_next) + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
      best_size  <= '0;
      best_row   <= '0;
      best_col   <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CW'(MAX_COLS - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
      if (a_fire) begin
        if (a_flags.last) begin
          best_size <= '0;
          best_row  <= '0;
          best_col  <= '0;
        end else begin
          best_size <= best_size_next;
          best_row  <= best_row_next;
          best_col  <= best_col_next;
        end
      end
      if (a_fire && a_flags.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/largest_ones_square_finder.sv */
// Flow: an accepted item is queued, then taken into the work stage with its line-buffer read
// and worked; a frame's result is registered on the outputs when its last pixel is worked.
// Throughput: one pixel item per cycle, set by the single line-buffer read and write per pixel,
// unless a sweep runs or a result waits on out_ready. Reset: rst is synchronous, active high;
// afterwards the line buffer is swept to zero with in_ready low; columns can still be written.
module largest_ones_square_finder import lsq_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [COLS_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              pixel,
  input  logic              frame_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIZE_W-1:0] square_size,
  output logic [SIZE_W-1:0] top_row,
  output logic [SIZE_W-1:0] left_column
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int QW = $bits(lsq_flags_t) + CW + RW;

  // Each queued item carries its flags, its pinned column and its row.
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic          clearing;

  // The front part keeps the columns register and the raster position, and
  // classifies every item as it is accepted.
  lsq_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW),
    .QW       (QW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_last  (frame_last),
    .q_full      (q_full),
    .clearing    (clearing),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // A short queue lets the front keep taking items while the back waits on
  // a result that has not yet been taken.
  lsq_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_wdata),
    .pop   (q_pop),
    .dout  (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back part reads the line buffer, forms the square size, tracks the
  // best square and holds the frame's result in an output register.
  lsq_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW),
    .QW       (QW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .square_size (square_size),
    .top_row     (top_row),
    .left_column (left_column)
  );

`ifndef SYNTHESIS
  a_no_items_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted while the line buffer is being cleared");

  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty && !clearing)
    else $error("queue read while empty or during clearing");
`endif

endmodule

/* dv/largest_ones_square_finder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the largest all-ones square finder, with its own square predictor.
module largest_ones_square_finder_tb;
  import lsq_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  // The block works an item once it has passed the queue and the work stage, so a few spare cycles
  // are enough to be sure that a pixel which gives no result has been absorbed.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_PIXELS = 520;
  localparam int DIR_ROWS = 28;
  // A frame that is cut short sends no more than this many pixels.
  localparam int BROKEN_MAX = 48;

  // One frame result: side of the best square and its 1-based top-left corner.
  typedef struct packed {
    logic [SIZE_W-1:0] side;
    logic [SIZE_W-1:0] row;
    logic [SIZE_W-1:0] col;
  } sq_result_t;

  typedef enum logic {DIR_PIXEL, DIR_COLUMNS} dir_kind_t;

  // A row of the directed stimulus is either a pixel item or a write of the row width.
  // Where typed is set, the expected result is taken from the row instead of the predictor.
  typedef struct packed {
    dir_kind_t kind;
    logic [COLS_W-1:0] value;
    logic pix;
    logic last;
    logic typed;
    sq_result_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COLS_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic pixel;
  logic frame_last;
  logic out_valid;
  logic out_ready;
  logic [SIZE_W-1:0] square_size;
  logic [SIZE_W-1:0] top_row;
  logic [SIZE_W-1:0] left_column;

  largest_ones_square_finder #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .frame_last(frame_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .square_size(square_size),
    .top_row(top_row),
    .left_column(left_column)
  );

  // Free-running clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the sizes of the previous row, the left and upper-left neighbours,
  // the raster position within the frame and the best square found so far.
  logic [SIZE_W-1:0] line_sizes [MAX_COLS];
  logic [SIZE_W-1:0] left_run;
  logic [SIZE_W-1:0] diag_run;
  logic [SIZE_W-1:0] best_side;
  logic [COLS_W-1:0] row_width;
  int unsigned col_at;
  int unsigned row_at;
  int unsigned best_top;
  int unsigned best_left;

  // Frame results still owed by the block, oldest first.
  sq_result_t awaited_squares [$];
  sq_result_t head_result;

  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned frames_sent;
  int unsigned results_seen;
  int unsigned width_writes;
  bit steady;
  bit hold_outputs;

  dir_row_t directed_rows [DIR_ROWS];

  // Every mismatch goes through here so that it is printed once and counted once.
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_frame();
    left_run = '0;
    diag_run = '0;
    col_at = 0;
    row_at = 0;
    best_side = '0;
    best_top = 0;
    best_left = 0;
  endfunction

  // Advances the predictor by one pixel. The size of the square ending at a one is one
  // more than the smallest of its left, upper and upper-left neighbours; a zero ends all
  // squares through it. Only a strictly larger square displaces the best, so the square
  // met first in raster order keeps a tie. Returns 1 when the pixel closes the frame.
  function automatic bit square_step(input logic pix, input logic last,
                                     output sq_result_t res);
    int unsigned ncols;
    int unsigned c;
    int unsigned up;
    int unsigned diag;
    int unsigned left;
    int unsigned side;
    // A width of zero behaves as one column, anything above the buffer as a full buffer.
    ncols = (row_width == '0) ? 1 : ((row_width > MAX_COLS) ? MAX_COLS : row_width);
    // If the width shrank mid-row, the column is held at the new last column.
    c = (col_at >= ncols) ? ncols - 1 : col_at;
    // Above the first row and left of the first column everything counts as zero.
    up = (row_at == 0) ? 0 : line_sizes[c];
    diag = (row_at == 0 || c == 0) ? 0 : diag_run;
    left = (c == 0) ? 0 : left_run;
    side = 0;
    if (pix) begin
      side = (left < up) ? left : up;
      side = ((side < diag) ? side : diag) + 1;
      if (side > SIZE_SAT) side = SIZE_SAT;
    end
    diag_run = SIZE_W'(up);
    line_sizes[c] = SIZE_W'(side);
    left_run = SIZE_W'(side);
    if (side > best_side) begin
      best_side = SIZE_W'(side);
      // Once the row counter has saturated a square may seem to start above the image.
      best_top = (side <= row_at + 1) ? row_at + 1 - side : 0;
      best_left = (side <= c + 1) ? c + 1 - side : 0;
    end
    if (c + 1 >= ncols) begin
      col_at = 0;
      if (row_at < MAX_ROWS - 1) row_at++;
    end else begin
      col_at = c + 1;
    end
    res.side = best_side;
    res.row = SIZE_W'(best_top + 1);
    res.col = SIZE_W'(best_left + 1);
    if (last) clear_frame();
    return last;
  endfunction

  // Offers one pixel item and holds it until it is taken; the prediction is made at the
  // edge of acceptance. Called just after a rising edge, so the drive lands on that edge.
  task automatic push_pixel(input logic pix, input logic last);
    sq_result_t res;
    in_valid <= 1'b1;
    pixel <= pix;
    frame_last <= last;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (square_step(pix, last, res)) begin
      awaited_squares = {awaited_squares, res};
      frames_sent++;
    end
  endtask

  // Now and then the sender goes quiet for a short burst, except in the closing stretch.
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stops offering items and waits until every owed result has come back and the last
  // pixel has surely passed through the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_squares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The row width is only changed while the block has nothing in flight.
  task automatic set_columns(input logic [COLS_W-1:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    row_width = value;
    width_writes++;
  endtask

  // Sends one frame of the given number of rows at the current width. Pixels are ones
  // with the given chance, and the final tail_ones pixels are forced to one. A broken
  // frame is cut off at a random pixel early on; a reshaped one has its width changed
  // halfway.
  task automatic run_frame(input int unsigned rows, input int unsigned ones_pct,
                           input int unsigned tail_ones, input bit broken,
                           input bit reshape);
    int unsigned ncols;
    int unsigned total;
    int unsigned cut;
    logic pix;
    ncols = (row_width == '0) ? 1 : ((row_width > MAX_COLS) ? MAX_COLS : row_width);
    total = rows * ncols;
    cut = broken ? $urandom_range(1, (total < BROKEN_MAX) ? total : BROKEN_MAX) : total;
    for (int unsigned i = 0; i < cut; i++) begin
      if (reshape && i == cut / 2 && i != 0) set_columns(COLS_W'($urandom_range(1, 8)));
      pix = (i + tail_ones >= total) ? 1'b1 : ($urandom_range(0, 99) < ones_pct);
      push_pixel(pix, i == cut - 1);
      sender_gap();
    end
  endtask

  // Results are taken at the edge on the values that stood before it, and each one is
  // held against the oldest prediction still waiting.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited_squares.size() == 0) begin
        flag_mismatch("result with no frame outstanding, square_size", square_size, 0);
      end else begin
        head_result = awaited_squares.pop_front();
        if (square_size !== head_result.side)
          flag_mismatch("square_size", square_size, head_result.side);
        if (top_row !== head_result.row)
          flag_mismatch("top_row", top_row, head_result.row);
        if (left_column !== head_result.col)
          flag_mismatch("left_column", left_column, head_result.col);
      end
    end
  end

  // Receiver: mostly ready, with random bursts of back-pressure. When asked, it holds
  // off for a long stretch so that results pile up and the block has to stall its input,
  // then stays ready until the sender withdraws the request.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_outputs) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        while (hold_outputs) @(posedge clk);
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: a directed walk first, then a back-pressure burst, then random phases.
  initial begin
    int unsigned random_start;
    int unsigned rows;
    int unsigned pct;
    logic [COLS_W-1:0] width;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    pixel <= 1'b0;
    frame_last <= 1'b0;
    steady = 1'b0;
    hold_outputs = 1'b0;
    mismatches = 0;
    pixels_sent = 0;
    frames_sent = 0;
    results_seen = 0;
    width_writes = 0;
    foreach (line_sizes[i]) line_sizes[i] = '0;
    row_width = COLUMNS_RESET;
    clear_frame();

    // Directed rows. The typed answers are the obvious ones: an empty frame straight after
    // reset, a lone one, a single column of ones, a one in the second column of a full-width
    // row and a 2 by 2 block of ones. The width writes cover zero, the top of the register,
    // and a change from four to two columns in the middle of a row.
    directed_rows = '{
      '{DIR_PIXEL,   11'd0,    1'b0, 1'b1, 1'b1, '{11'd0, 11'd1, 11'd1}},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b1, 1'b1, '{11'd1, 11'd1, 11'd1}},
      '{DIR_COLUMNS, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b1, 1'b1, '{11'd1, 11'd1, 11'd1}},
      '{DIR_COLUMNS, 11'd2047, 1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b1, 1'b1, '{11'd1, 11'd1, 11'd2}},
      '{DIR_COLUMNS, 11'd2,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b1, 1'b1, '{11'd2, 11'd1, 11'd1}},
      '{DIR_COLUMNS, 11'd3,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b1, 1'b0, '0},
      '{DIR_COLUMNS, 11'd4,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_COLUMNS, 11'd2,    1'b0, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{DIR_PIXEL,   11'd0,    1'b1, 1'b1, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The block sweeps its line buffer after reset with in_ready low; the first item simply
    // waits for the handshake.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == DIR_COLUMNS) begin
        set_columns(directed_rows[i].value);
      end else begin
        push_pixel(directed_rows[i].pix, directed_rows[i].last);
        if (directed_rows[i].typed) awaited_squares[$] = directed_rows[i].want;
        sender_gap();
      end
    end

    // Back-pressure: the receiver holds off while the sender keeps offering one-pixel frames,
    // so items back up behind the held result and the input stalls. Then the sender waits for all.
    set_columns(COLS_W'($urandom_range(1, 8)));
    hold_outputs = 1'b1;
    repeat (16) push_pixel(logic'($urandom_range(0, 1)), 1'b1);
    hold_outputs = 1'b0;
    settle();

    // Random phases: a width for each phase, then a few frames. Most frames are well formed
    // with dense ones so that large squares grow; some are cut short or reshaped midway.
    // Wide rows are always cut short to keep the run brief.
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      if (pixels_sent - random_start >= RANDOM_PIXELS - 80) steady = 1'b1;
      case ($urandom_range(0, 19))
        0: width = '0;
        1: width = '1;
        2: width = steady ? COLS_W'($urandom_range(1, 8)) : COLS_W'(MAX_COLS);
        3: width = COLS_W'($urandom_range(9, 40));
        default: width = COLS_W'($urandom_range(1, 8));
      endcase
      set_columns(width);
      repeat ($urandom_range(1, 3)) begin
        if (width > 40) begin
          rows = 1;
        end else if (width > 8) begin
          rows = $urandom_range(1, 3);
        end else begin
          rows = $urandom_range(1, 8);
        end
        case ($urandom_range(0, 4))
          0: pct = 0;
          1: pct = 50;
          2: pct = 85;
          default: pct = 100;
        endcase
        run_frame(rows, pct, 0, (width > 40) || ($urandom_range(0, 7) == 0),
                  $urandom_range(0, 9) == 0);
      end
    end

    // Closing: let every owed result come back, then watch a little longer for strays.
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_squares.size() != 0)
      flag_mismatch("frames left without a result", awaited_squares.size(), 0);

    $display("Run covered %0d pixel items in %0d frames with %0d results taken.",
             pixels_sent, frames_sent, results_seen);
    $display("Row width was written %0d times, from zero to the register's top, mid-row too.",
             width_writes);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the sweep after reset.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lsq_pkg.sv
rtl/core/lsq_front.sv
rtl/core/lsq_queue.sv
rtl/core/lsq_back.sv
rtl/core/largest_ones_square_finder.sv
dv/largest_ones_square_finder_tb.sv
